>>> hdl/ptob_pkg.sv
// shared types, codes and ranking function for the price-time order book
`timescale 1ns / 1ps
package ptob_pkg;

    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_CANCEL   = 3'd1;
    localparam logic [2:0] KIND_TAKE_BID = 3'd2;
    localparam logic [2:0] KIND_TAKE_ASK = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_BADQTY   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_APPLY,
        S_SCAN2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [30:0] qty;
        logic [15:0] symbol;
        logic [31:0] stamp;
    } entry_t;

    // write controls toward the order table
    typedef struct packed {
        logic wr_en;
        logic v_set;
        logic v_clr;
    } tbl_cmd_t;

    // true when a candidate outranks the held best of side sd
    function automatic logic outranks(
        input logic        found,
        input logic        sd,
        input logic [31:0] p,
        input logic [31:0] age,
        input logic [31:0] bp,
        input logic [31:0] ba
    );
        logic r;
        if (!found)
            r = 1'b1;
        else if (p != bp)
            r = sd ? (p < bp) : (p > bp);
        else
            r = age > ba;
        return r;
    endfunction

endpackage

>>> hdl/ptob_table.sv
// order table: entry memory with registered read and per-slot valid flags
`timescale 1ns / 1ps
module ptob_table #(
    parameter int MAX_ORDERS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(MAX_ORDERS)-1:0] raddr,
    output ptob_pkg::entry_t              rdata,
    output logic                          rvalid,
    input  ptob_pkg::tbl_cmd_t            cmd,
    input  logic [$clog2(MAX_ORDERS)-1:0] waddr,
    input  ptob_pkg::entry_t              wdata
);

    ptob_pkg::entry_t mem [MAX_ORDERS];
    logic [MAX_ORDERS-1:0] valid_reg;
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.v_set)
                valid_reg[waddr] <= 1'b1;
            else if (cmd.v_clr)
                valid_reg[waddr] <= 1'b0;
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rvalid = rvalid_reg;

endmodule

>>> hdl/price_time_order_book_core.sv
// Price-time order book core. For each accepted word, one pass over the order table
// reads one slot a cycle through the table's single read port to find the id match,
// the lowest free slot and the consume target, the apply state applies the change,
// and a second pass finds the best bid and best ask; the result then waits in the
// output register until taken. in_stall is high from acceptance until the result
// is taken, so the core takes no new word while one is in flight. Table contents
// need no clearing after reset.
`timescale 1ns / 1ps
module price_time_order_book_core #(
    parameter int MAX_ORDERS  = 256,
    parameter int SYMBOL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] order_id,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [30:0] quantity,
    input  logic [15:0] symbol_id,
    input  logic        use_symbol,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [2:0]  status,
    output logic        bid_valid,
    output logic [31:0] bid_price,
    output logic        ask_valid,
    output logic [31:0] ask_price,
    output logic [31:0] bid_order,
    output logic [31:0] ask_order,
    output logic [8:0]  live_total,
    output logic [8:0]  buy_total,
    output logic [8:0]  sell_total,
    output logic [30:0] lookup_qty
);

    localparam int IW = $clog2(MAX_ORDERS);
    localparam int CW = $clog2(MAX_ORDERS + 1);
    localparam logic [IW:0] LAST = (IW + 1)'(MAX_ORDERS);
    localparam logic [15:0] SYM_MASK =
        (SYMBOL_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SYMBOL_BITS) - 32'd1);

    ptob_pkg::state_t state_reg, state_next;

    // latched word
    logic [2:0]  kind_reg;
    logic [31:0] id_reg, price_reg;
    logic        side_reg, usym_reg;
    logic [30:0] qty_reg;
    logic [15:0] sym_reg;

    logic [IW:0] cnt_reg, cnt_next;
    logic [31:0] arrival_reg;
    logic [CW-1:0] buy_reg, sell_reg;

    // first pass results
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          hit_side_reg;
    logic [30:0]   hit_qty_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          tgt_reg;
    logic [IW-1:0] tgt_idx_reg;
    logic [31:0]   tgt_age_reg;
    ptob_pkg::entry_t tgt_ent_reg;

    // second pass results
    logic        bb_reg, ba_reg;
    logic [31:0] bb_price_reg, bb_age_reg, bb_id_reg;
    logic [31:0] ba_price_reg, ba_age_reg, ba_id_reg;

    // result register
    logic        acc_reg;
    logic [2:0]  status_reg;
    logic [30:0] lookup_reg;

    // table ports
    ptob_pkg::entry_t   rdata, wdata;
    logic               rvalid;
    ptob_pkg::tbl_cmd_t cmd;
    logic [IW-1:0]      waddr;

    ptob_table #(.MAX_ORDERS(MAX_ORDERS)) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata),
        .rvalid(rvalid),
        .cmd   (cmd),
        .waddr (waddr),
        .wdata (wdata)
    );

    // slot whose data is on the read port this cycle
    logic          p_ok;
    logic [IW-1:0] p_idx;
    logic [31:0]   p_age;
    logic          sym_ok, filt2, tgt_cand;

    assign p_ok   = (cnt_reg != '0) && rvalid;
    assign p_idx  = IW'(cnt_reg - (IW + 1)'(1));
    assign p_age  = arrival_reg - rdata.stamp;
    assign sym_ok = rdata.symbol == sym_reg;
    assign filt2  = (kind_reg == ptob_pkg::KIND_QUERY) && usym_reg;
    assign tgt_cand = p_ok && (rdata.side == (kind_reg == ptob_pkg::KIND_TAKE_ASK))
                      && (!usym_reg || sym_ok);

    logic [30:0] left_qty;
    assign left_qty = tgt_ent_reg.qty - qty_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        waddr      = free_idx_reg;
        wdata      = '0;
        wdata.id     = id_reg;
        wdata.side   = side_reg;
        wdata.price  = price_reg;
        wdata.qty    = qty_reg;
        wdata.symbol = sym_reg;
        wdata.stamp  = arrival_reg;
        unique case (state_reg)
            ptob_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptob_pkg::S_SCAN1;
                    cnt_next   = '0;
                end
            end
            ptob_pkg::S_SCAN1:
            begin
                cnt_next = cnt_reg + (IW + 1)'(1);
                if (cnt_reg == LAST)
                    state_next = ptob_pkg::S_APPLY;
            end
            ptob_pkg::S_APPLY:
            begin
                cnt_next   = '0;
                state_next = ptob_pkg::S_SCAN2;
                priority case (kind_reg)
                    ptob_pkg::KIND_ADD:
                    begin
                        if (!hit_reg && free_reg)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.v_set = 1'b1;
                        end
                    end
                    ptob_pkg::KIND_CANCEL:
                    begin
                        waddr     = hit_idx_reg;
                        cmd.v_clr = hit_reg;
                    end
                    ptob_pkg::KIND_TAKE_BID, ptob_pkg::KIND_TAKE_ASK:
                    begin
                        waddr     = tgt_idx_reg;
                        wdata     = tgt_ent_reg;
                        wdata.qty = left_qty;
                        if (tgt_reg && qty_reg != '0 && qty_reg <= tgt_ent_reg.qty)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.v_clr = left_qty == '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ptob_pkg::S_SCAN2:
            begin
                cnt_next = cnt_reg + (IW + 1)'(1);
                if (cnt_reg == LAST)
                    state_next = ptob_pkg::S_DONE;
            end
            ptob_pkg::S_DONE:
            begin
                if (!out_stall)
                    state_next = ptob_pkg::S_IDLE;
            end
            default:
                state_next = ptob_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ptob_pkg::S_IDLE;
            cnt_reg     <= '0;
            arrival_reg <= '0;
            buy_reg     <= '0;
            sell_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ptob_pkg::S_APPLY)
            begin
                if (cmd.v_set)
                begin
                    arrival_reg <= arrival_reg + 32'd1;
                    if (side_reg)
                        sell_reg <= sell_reg + CW'(1);
                    else
                        buy_reg <= buy_reg + CW'(1);
                end
                else if (cmd.v_clr)
                begin
                    if (kind_reg == ptob_pkg::KIND_CANCEL ? hit_side_reg : tgt_ent_reg.side)
                        sell_reg <= sell_reg - CW'(1);
                    else
                        buy_reg <= buy_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ptob_pkg::S_IDLE && in_valid)
        begin
            kind_reg  <= kind;
            id_reg    <= order_id;
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= quantity;
            sym_reg   <= symbol_id & SYM_MASK;
            usym_reg  <= use_symbol;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            tgt_reg   <= 1'b0;
        end
        if (state_reg == ptob_pkg::S_SCAN1 && cnt_reg != '0)
        begin
            if (!rvalid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= p_idx;
            end
            if (p_ok && !hit_reg && rdata.id == id_reg)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= p_idx;
                hit_side_reg <= rdata.side;
                hit_qty_reg  <= rdata.qty;
            end
            if (tgt_cand && ptob_pkg::outranks(tgt_reg, rdata.side, rdata.price, p_age,
                                               tgt_ent_reg.price, tgt_age_reg))
            begin
                tgt_reg     <= 1'b1;
                tgt_idx_reg <= p_idx;
                tgt_age_reg <= p_age;
                tgt_ent_reg <= rdata;
            end
        end
        if (state_reg == ptob_pkg::S_APPLY)
        begin
            bb_reg     <= 1'b0;
            ba_reg     <= 1'b0;
            acc_reg    <= 1'b0;
            status_reg <= ptob_pkg::ST_OK;
            lookup_reg <= '0;
            priority case (kind_reg)
                ptob_pkg::KIND_ADD:
                begin
                    if (hit_reg)
                        status_reg <= ptob_pkg::ST_DUP;
                    else if (!free_reg)
                        status_reg <= ptob_pkg::ST_FULL;
                    else
                        acc_reg <= 1'b1;
                end
                ptob_pkg::KIND_CANCEL, ptob_pkg::KIND_QUERY:
                begin
                    if (hit_reg)
                    begin
                        acc_reg <= 1'b1;
                        if (kind_reg == ptob_pkg::KIND_QUERY)
                            lookup_reg <= hit_qty_reg;
                    end
                    else
                        status_reg <= ptob_pkg::ST_NOTFOUND;
                end
                ptob_pkg::KIND_TAKE_BID, ptob_pkg::KIND_TAKE_ASK:
                begin
                    if (!tgt_reg)
                        status_reg <= ptob_pkg::ST_NOTFOUND;
                    else if (qty_reg == '0 || qty_reg > tgt_ent_reg.qty)
                        status_reg <= ptob_pkg::ST_BADQTY;
                    else
                        acc_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ptob_pkg::S_SCAN2 && p_ok && (!filt2 || sym_ok))
        begin
            if (!rdata.side && ptob_pkg::outranks(bb_reg, 1'b0, rdata.price, p_age,
                                                  bb_price_reg, bb_age_reg))
            begin
                bb_reg       <= 1'b1;
                bb_price_reg <= rdata.price;
                bb_age_reg   <= p_age;
                bb_id_reg    <= rdata.id;
            end
            if (rdata.side && ptob_pkg::outranks(ba_reg, 1'b1, rdata.price, p_age,
                                                 ba_price_reg, ba_age_reg))
            begin
                ba_reg       <= 1'b1;
                ba_price_reg <= rdata.price;
                ba_age_reg   <= p_age;
                ba_id_reg    <= rdata.id;
            end
        end
    end

    assign in_stall   = state_reg != ptob_pkg::S_IDLE;
    assign out_valid  = state_reg == ptob_pkg::S_DONE;
    assign accepted   = acc_reg;
    assign status     = status_reg;
    assign bid_valid  = bb_reg;
    assign bid_price  = bb_reg ? bb_price_reg : '0;
    assign bid_order  = bb_reg ? bb_id_reg : '0;
    assign ask_valid  = ba_reg;
    assign ask_price  = ba_reg ? ba_price_reg : '0;
    assign ask_order  = ba_reg ? ba_id_reg : '0;
    assign live_total = 9'((CW + 1)'(buy_reg) + (CW + 1)'(sell_reg));
    assign buy_total  = 9'(buy_reg);
    assign sell_total = 9'(sell_reg);
    assign lookup_qty = lookup_reg;

    // book never holds more orders than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(buy_reg) + (CW + 1)'(sell_reg) <= (CW + 1)'(MAX_ORDERS))
        else $error("order counts exceed table size");

    // counts move only in the apply cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ptob_pkg::S_APPLY |=> $stable(buy_reg) && $stable(sell_reg))
        else $error("order count changed outside apply");

    // an accepted word always leads to a pass over the table
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ptob_pkg::S_SCAN1 && cnt_reg == '0)
        else $error("accepted word did not start a scan");

    // arrival counter advances only on a successful add
    assert property (@(posedge clk) disable iff (!rst_n)
        arrival_reg != $past(arrival_reg) |-> $past(cmd.v_set))
        else $error("arrival counter moved without an add");

endmodule

>>> verif/price_time_order_book_core_tb.sv
// testbench for the price-time order book core: directed and random words checked against a model
`timescale 1ns / 1ps
module price_time_order_book_core_tb;

    localparam int SLOTS = 256;
    localparam int PEND_DEPTH = 16;
    localparam int RECENT_DEPTH = 40;

    typedef struct packed {
        logic        acc;
        logic [2:0]  st;
        logic        bv;
        logic [31:0] bp;
        logic        av;
        logic [31:0] ap;
        logic [31:0] bo;
        logic [31:0] ao;
        logic [8:0]  lt;
        logic [8:0]  bt;
        logic [8:0]  stt;
        logic [30:0] lq;
    } book_view_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [30:0] quantity;
    logic [15:0] symbol_id;
    logic        use_symbol;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic [2:0]  status;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] bid_order;
    logic [31:0] ask_order;
    logic [8:0]  live_total;
    logic [8:0]  buy_total;
    logic [8:0]  sell_total;
    logic [30:0] lookup_qty;

    price_time_order_book_core uut (.*);

    // book copy
    bit          bk_live[SLOTS];
    logic [31:0] bk_id[SLOTS];
    logic        bk_side[SLOTS];
    logic [31:0] bk_price[SLOTS];
    logic [30:0] bk_qty[SLOTS];
    logic [15:0] bk_sym[SLOTS];
    logic [31:0] bk_stamp[SLOTS];
    logic [31:0] arrivals;
    int          buys;
    int          sells;

    // expected results in order, as a ring
    book_view_t  pending_views[PEND_DEPTH];
    int          pend_wr;
    int          pend_rd;
    int          errors;
    bit          stall_free;
    logic [31:0] recent_ids[RECENT_DEPTH];
    int          recent_cnt;
    int          recent_pos;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int slot_of(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bk_live[i] && bk_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_slot(logic sd, bit filt, logic [15:0] sym);
        int          best;
        logic [31:0] bp;
        logic [31:0] ba;
        logic [31:0] age;
        bit          better;
        best = -1;
        bp = '0;
        ba = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!bk_live[i] || bk_side[i] != sd)
                continue;
            if (filt && bk_sym[i] != sym)
                continue;
            age = arrivals - bk_stamp[i];
            if (best < 0)
                better = 1'b1;
            else if (bk_price[i] != bp)
                better = sd ? (bk_price[i] < bp) : (bk_price[i] > bp);
            else
                better = age > ba;
            if (better)
            begin
                best = i;
                bp = bk_price[i];
                ba = age;
            end
        end
        return best;
    endfunction

    function automatic void remove_order(int i);
        bk_live[i] = 1'b0;
        if (bk_side[i])
            sells--;
        else
            buys--;
    endfunction

    function automatic book_view_t apply_word(logic [2:0] k, logic [31:0] id, logic sd,
                                              logic [31:0] p, logic [30:0] q,
                                              logic [15:0] sym, logic us);
        book_view_t v;
        int         i;
        int         bb;
        int         ba;
        bit         filt;
        v = '0;
        filt = 1'b0;
        v.st = ptob_pkg::ST_OK;
        case (k)
            ptob_pkg::KIND_ADD:
            begin
                i = -1;
                for (int j = 0; j < SLOTS && i < 0; j++)
                    if (!bk_live[j])
                        i = j;
                if (slot_of(id) >= 0)
                    v.st = ptob_pkg::ST_DUP;
                else if (i < 0)
                    v.st = ptob_pkg::ST_FULL;
                else
                begin
                    bk_live[i] = 1'b1;
                    bk_id[i] = id;
                    bk_side[i] = sd;
                    bk_price[i] = p;
                    bk_qty[i] = q;
                    bk_sym[i] = sym;
                    bk_stamp[i] = arrivals;
                    arrivals++;
                    if (sd)
                        sells++;
                    else
                        buys++;
                    v.acc = 1'b1;
                end
            end
            ptob_pkg::KIND_CANCEL:
            begin
                i = slot_of(id);
                if (i < 0)
                    v.st = ptob_pkg::ST_NOTFOUND;
                else
                begin
                    remove_order(i);
                    v.acc = 1'b1;
                end
            end
            ptob_pkg::KIND_TAKE_BID, ptob_pkg::KIND_TAKE_ASK:
            begin
                i = best_slot(k == ptob_pkg::KIND_TAKE_ASK, us, sym);
                if (i < 0)
                    v.st = ptob_pkg::ST_NOTFOUND;
                else if (q == '0 || q > bk_qty[i])
                    v.st = ptob_pkg::ST_BADQTY;
                else
                begin
                    bk_qty[i] -= q;
                    if (bk_qty[i] == '0)
                        remove_order(i);
                    v.acc = 1'b1;
                end
            end
            ptob_pkg::KIND_QUERY:
            begin
                filt = us;
                i = slot_of(id);
                if (i < 0)
                    v.st = ptob_pkg::ST_NOTFOUND;
                else
                begin
                    v.lq = bk_qty[i];
                    v.acc = 1'b1;
                end
            end
            default: ;
        endcase
        bb = best_slot(1'b0, filt, sym);
        ba = best_slot(1'b1, filt, sym);
        if (bb >= 0)
        begin
            v.bv = 1'b1;
            v.bp = bk_price[bb];
            v.bo = bk_id[bb];
        end
        if (ba >= 0)
        begin
            v.av = 1'b1;
            v.ap = bk_price[ba];
            v.ao = bk_id[ba];
        end
        v.lt = 9'(buys + sells);
        v.bt = 9'(buys);
        v.stt = 9'(sells);
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // valid stays high across a zero gap, the next word simply follows
    task automatic send_word(logic [2:0] k, logic [31:0] id, logic sd, logic [31:0] p,
                             logic [30:0] q, logic [15:0] sym, logic us);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        order_id <= id;
        side <= sd;
        price <= p;
        quantity <= q;
        symbol_id <= sym;
        use_symbol <= us;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_views[pend_wr % PEND_DEPTH] = apply_word(k, id, sd, p, q, sym, us);
        pend_wr++;
    endtask

    // checker samples on the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            book_view_t w;
            if (pend_wr == pend_rd)
                report_mismatch("unexpected word", 32'd0, 32'd0);
            else
            begin
                w = pending_views[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (accepted !== w.acc)
                    report_mismatch("accepted", 32'(accepted), 32'(w.acc));
                if (status !== w.st)
                    report_mismatch("status", 32'(status), 32'(w.st));
                if (bid_valid !== w.bv)
                    report_mismatch("bid_valid", 32'(bid_valid), 32'(w.bv));
                if (bid_price !== w.bp)
                    report_mismatch("bid_price", bid_price, w.bp);
                if (ask_valid !== w.av)
                    report_mismatch("ask_valid", 32'(ask_valid), 32'(w.av));
                if (ask_price !== w.ap)
                    report_mismatch("ask_price", ask_price, w.ap);
                if (bid_order !== w.bo)
                    report_mismatch("bid_order", bid_order, w.bo);
                if (ask_order !== w.ao)
                    report_mismatch("ask_order", ask_order, w.ao);
                if (live_total !== w.lt)
                    report_mismatch("live_total", 32'(live_total), 32'(w.lt));
                if (buy_total !== w.bt)
                    report_mismatch("buy_total", 32'(buy_total), 32'(w.bt));
                if (sell_total !== w.stt)
                    report_mismatch("sell_total", 32'(sell_total), 32'(w.stt));
                if (lookup_qty !== w.lq)
                    report_mismatch("lookup_qty", 32'(lookup_qty), 32'(w.lq));
            end
        end
    end

    // receiver backpressure, with stall-free stretches
    always @(posedge clk)
    begin
        if (stall_free)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            out_stall <= 1'b0;
    end

    task automatic test_directed();
        send_word(ptob_pkg::KIND_QUERY, 32'h0, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_TAKE_BID, 32'h0, 1'b0, 32'h0, 31'h5, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_TAKE_ASK, 32'h0, 1'b0, 32'h0, 31'h5, 16'h0, 1'b1);
        send_word(ptob_pkg::KIND_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                  16'hFFFF, 1'b1);
        send_word(ptob_pkg::KIND_ADD, 32'h0, 1'b1, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'h1, 1'b0, 32'hFFFF_FFFF, 31'h10, 16'h1, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'h2, 1'b1, 32'h100, 31'h10, 16'h1, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'h3, 1'b1, 32'h100, 31'h8, 16'h2, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'h1, 1'b1, 32'h5, 31'h3, 16'h1, 1'b0);
        send_word(ptob_pkg::KIND_TAKE_BID, 32'h0, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_TAKE_BID, 32'h0, 1'b0, 32'h0, 31'h7FFF_FFFF, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_TAKE_BID, 32'h0, 1'b0, 32'h0, 31'h7FFF_FFFF, 16'hFFFF,
                  1'b1);
        send_word(ptob_pkg::KIND_TAKE_ASK, 32'h0, 1'b0, 32'h0, 31'h8, 16'h2, 1'b1);
        send_word(ptob_pkg::KIND_TAKE_ASK, 32'h0, 1'b0, 32'h0, 31'h4, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_QUERY, 32'h2, 1'b0, 32'h0, 31'h0, 16'h1, 1'b1);
        send_word(ptob_pkg::KIND_QUERY, 32'h0, 1'b0, 32'h0, 31'h0, 16'h7, 1'b1);
        send_word(ptob_pkg::KIND_CANCEL, 32'h0, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(3'd5, 32'h1, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1);
    endtask

    // fill the table to force the table full status, then drain
    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_word(ptob_pkg::KIND_ADD, 32'h1000 + i, i[0], 32'(i % 7), 31'd1,
                      16'(i % 3), 1'b0);
        for (int i = 0; i < SLOTS + 2; i += 9)
            send_word(ptob_pkg::KIND_CANCEL, 32'h1000 + i, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
        send_word(ptob_pkg::KIND_ADD, 32'h1000, 1'b1, 32'h3, 31'd2, 16'h0, 1'b0);
        for (int i = 0; i < SLOTS + 2; i++)
            send_word(ptob_pkg::KIND_CANCEL, 32'h1000 + i, 1'b0, 32'h0, 31'h0, 16'h0, 1'b0);
    endtask

    task automatic test_random(int n);
        logic [2:0]  k;
        logic [31:0] id;
        logic [30:0] q;
        int          r;
        for (int t = 0; t < n; t++)
        begin
            stall_free = (t % 150) < 30;
            r = $urandom_range(0, 99);
            k = r < 40 ? ptob_pkg::KIND_ADD : r < 52 ? ptob_pkg::KIND_CANCEL :
                r < 67 ? ptob_pkg::KIND_TAKE_BID : r < 82 ? ptob_pkg::KIND_TAKE_ASK :
                r < 97 ? ptob_pkg::KIND_QUERY : 3'($urandom_range(5, 7));
            if (recent_cnt > 0 && $urandom_range(0, 2) != 0)
                id = recent_ids[$urandom_range(0, recent_cnt - 1)];
            else if ($urandom_range(0, 3) == 0)
                id = $urandom;
            else
                id = $urandom_range(0, 63);
            if (k == ptob_pkg::KIND_ADD)
            begin
                recent_ids[recent_pos] = id;
                recent_pos = (recent_pos + 1) % RECENT_DEPTH;
                if (recent_cnt < RECENT_DEPTH)
                    recent_cnt++;
            end
            case ($urandom_range(0, 5))
                0: q = 31'($urandom);
                1: q = '0;
                default: q = 31'($urandom_range(1, 20));
            endcase
            send_word(k, id, 1'($urandom),
                      $urandom_range(0, 4) == 0 ? $urandom : 32'($urandom_range(95, 105)),
                      q,
                      $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
                      1'($urandom));
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        stall_free = 1'b0;
        arrivals = '0;
        buys = 0;
        sells = 0;
        pend_wr = 0;
        pend_rd = 0;
        recent_cnt = 0;
        recent_pos = 0;
        for (int i = 0; i < SLOTS; i++)
            bk_live[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = ptob_pkg::KIND_QUERY;
        order_id = '0;
        side = 1'b0;
        price = '0;
        quantity = '0;
        symbol_id = '0;
        use_symbol = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random(90);
        in_valid <= 1'b0;
        stall_free = 1'b1;
        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/ptob_pkg.sv
hdl/ptob_table.sv
hdl/price_time_order_book_core.sv
verif/price_time_order_book_core_tb.sv
